[hw/rtl/modular_inverse_euclid_core_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef MODULAR_INVERSE_EUCLID_CORE_MACROS_SVH
`define MODULAR_INVERSE_EUCLID_CORE_MACROS_SVH

// same-cycle implication
`define MIE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hw/rtl/mie_pkg.sv]
// Package for the modular inverse core: default operand width and sequencer states.
// No dependencies.
package mie_pkg;

   localparam int OPERAND_BITS_DEF = 31;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_DIV    = 6'b000100,
      ST_UPDATE = 6'b001000,
      ST_FIX    = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

endpackage

[hw/rtl/modular_inverse_euclid_core.sv]
// Modular inverse by the extended Euclidean iteration, one shared divide step unit.
// Depends on mie_pkg.
//
//   channel | direction | ports                              | handshake
//   req     | in        | req_value, req_modulus             | req_valid / req_stall
//   rsp     | out       | rsp_inverse, rsp_status            | rsp_valid / rsp_stall
//
// Each Euclid step is a check in CHECK, a restoring division in DIV (compare-subtract plus a
// shift-add of the quotient times the coefficient) and an update in UPDATE.
// req_stall is high from acceptance until the result is handed to the output register.
// A finished result waits in DONE while the output register holds an unaccepted item.
// Synchronous active-high reset clears the sequencer and rsp_valid.
module modular_inverse_euclid_core
   import mie_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OPERAND_BITS-1:0] req_value,
   input  logic [OPERAND_BITS-1:0] req_modulus,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [OPERAND_BITS-1:0] rsp_inverse,
   output logic                    rsp_status
);

   localparam int W        = OPERAND_BITS;
   localparam int CW       = OPERAND_BITS + 2;
   localparam int CNT_BITS = $clog2(OPERAND_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(OPERAND_BITS - 1);

   state_type               state_ff, state_in;
   logic [W-1:0]            a_ff, a_in;
   logic [W-1:0]            b_ff, b_in;
   logic [W-1:0]            mod_ff, mod_in;
   logic [W-1:0]            rem_ff, rem_in;
   logic signed [CW-1:0]    cp_ff, cp_in;
   logic signed [CW-1:0]    cc_ff, cc_in;
   logic signed [CW-1:0]    prod_ff, prod_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [W-1:0]            res_inv_ff, res_inv_in;
   logic                    res_stat_ff, res_stat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]            rsp_inverse_ff, rsp_inverse_in;
   logic                    rsp_status_ff, rsp_status_in;

   logic                    req_accept;
   logic                    rsp_free;
   logic [W:0]              r_sh;
   logic [W:0]              r_diff;
   logic                    ge;
   logic signed [CW-1:0]    cc_fix;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_inverse = rsp_inverse_ff;
   assign rsp_status  = rsp_status_ff;

   // shared divide step: shift in next dividend bit, trial subtract
   assign r_sh   = {rem_ff, a_ff[W-1]};
   assign r_diff = r_sh - {1'b0, b_ff};
   assign ge     = !r_diff[W];
   assign cc_fix = cc_ff + $signed({2'b00, mod_ff});

   always_comb begin
      state_in       = state_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      mod_in         = mod_ff;
      rem_in         = rem_ff;
      cp_in          = cp_ff;
      cc_in          = cc_ff;
      prod_in        = prod_ff;
      cnt_in         = cnt_ff;
      res_inv_in     = res_inv_ff;
      res_stat_in    = res_stat_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_inverse_in = rsp_inverse_ff;
      rsp_status_in  = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               a_in     = req_value;
               b_in     = req_modulus;
               mod_in   = req_modulus;
               cp_in    = '0;
               cc_in    = CW'(1);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (mod_ff == '0) begin
               res_inv_in  = '0;
               res_stat_in = 1'b1;
               state_in    = ST_DONE;
            end else if (mod_ff == W'(1)) begin
               res_inv_in  = W'(1);
               res_stat_in = 1'b0;
               state_in    = ST_DONE;
            end else if (a_ff <= W'(1)) begin
               state_in = ST_FIX;
            end else if (b_ff == '0) begin
               res_inv_in  = '0;
               res_stat_in = 1'b1;
               state_in    = ST_DONE;
            end else begin
               rem_in   = '0;
               prod_in  = '0;
               cnt_in   = CNT_LAST;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = ge ? r_diff[W-1:0] : r_sh[W-1:0];
            prod_in = (prod_ff <<< 1) + (ge ? cp_ff : '0);
            a_in    = {a_ff[W-2:0], 1'b0};
            cnt_in  = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            a_in     = b_ff;
            b_in     = rem_ff;
            cp_in    = cc_ff - prod_ff;
            cc_in    = cp_ff;
            state_in = ST_CHECK;
         end
         ST_FIX: begin
            res_inv_in  = cc_ff[CW-1] ? cc_fix[W-1:0] : cc_ff[W-1:0];
            res_stat_in = 1'b0;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_inverse_in = res_inv_ff;
               rsp_status_in  = res_stat_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff           <= a_in;
      b_ff           <= b_in;
      mod_ff         <= mod_in;
      rem_ff         <= rem_in;
      cp_ff          <= cp_in;
      cc_ff          <= cc_in;
      prod_ff        <= prod_in;
      cnt_ff         <= cnt_in;
      res_inv_ff     <= res_inv_in;
      res_stat_ff    <= res_stat_in;
      rsp_inverse_ff <= rsp_inverse_in;
      rsp_status_ff  <= rsp_status_in;
   end

endmodule

[hw/rtl/mie_checker.sv]
// Port-level checker for modular_inverse_euclid_core, with its bind.
// Depends on mie_pkg and modular_inverse_euclid_core_macros.svh.
`include "modular_inverse_euclid_core_macros.svh"

module mie_checker
   import mie_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [OPERAND_BITS-1:0] req_value,
   input logic [OPERAND_BITS-1:0] req_modulus,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [OPERAND_BITS-1:0] rsp_inverse,
   input logic                    rsp_status
);

   `MIE_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable({req_value, req_modulus}))
   `MIE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_inverse, rsp_status}))
   `MIE_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && rsp_status, rsp_inverse == '0)
   `MIE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `MIE_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind modular_inverse_euclid_core mie_checker #(.OPERAND_BITS(OPERAND_BITS)) u_checker (.*);
